### design/led_panel_selector_controller_core_defines.svh
// ----------------------------------------------------------------------------
// LED panel selector controller - assertion macros
// Concurrent check macros used by the core; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_PANEL_SELECTOR_CONTROLLER_CORE_DEFINES_SVH
`define LED_PANEL_SELECTOR_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LPSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpsc check failed");
`define LPSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpsc check failed");
`else
`define LPSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/lpsc_pkg.sv
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types, widths, codes and tables of the LED panel selector controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsc_pkg;

    localparam int DEB_W     = 8;
    localparam int POT_W     = 10;
    localparam int SCALE_W   = 8;
    localparam int BASE_W    = 14;
    localparam int FLASH_IW  = 14;
    localparam int PROD_W    = 16;
    localparam int BLINK_IW  = 17;
    localparam int CFG_W     = 14;
    localparam int SEL_W     = 3;
    localparam int NUM_LEDS  = 4;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_BASE      = 2'd1,
        CFG_POT_SCALE = 2'd2,
        CFG_RGB_BLINK = 2'd3
    } t_cfg_idx;

    localparam logic [DEB_W-1:0]    DEBOUNCE_RST  = 8'd25;
    localparam logic [BASE_W-1:0]   BASE_RST      = 14'd250;
    localparam logic [SCALE_W-1:0]  SCALE_RST     = 8'd10;
    localparam logic [FLASH_IW-1:0] RGB_BLINK_RST = 14'd250;

    localparam logic [SEL_W-1:0] SEL_RED  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_GRN  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_BLU  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_WHT  = 3'd3;
    localparam logic [SEL_W-1:0] SEL_NONE = 3'd4;

    localparam logic signed [3:0] DETENT_POS = 4'sd4;
    localparam logic signed [3:0] DETENT_NEG = -4'sd4;

    localparam logic signed [1:0] QUAD_STEP [16] = '{
        2'sd0,  -2'sd1, 2'sd1,  2'sd0,
        2'sd1,  2'sd0,  2'sd0,  -2'sd1,
        -2'sd1, 2'sd0,  2'sd0,  2'sd1,
        2'sd0,  2'sd1,  -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic up;
        logic dn;
    } t_detent;

    typedef struct packed {
        logic en;
        logic restart;
    } t_tmr_ctl;

    function automatic logic [2:0] rgb_of_sel(input logic [SEL_W-1:0] sel);
        logic [2:0] rgb;
        case (sel)
            SEL_RED: rgb = 3'b100;
            SEL_GRN: rgb = 3'b010;
            SEL_BLU: rgb = 3'b001;
            SEL_WHT: rgb = 3'b111;
            default: rgb = 3'b000;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

### design/lpsc_debounce.sv
// ----------------------------------------------------------------------------
// lpsc_debounce
// One button debouncer; flags a press when the settled level turns to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_debounce #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_level,
    input  wire logic [TIME_BITS-1:0]        i_now,
    input  wire logic [lpsc_pkg::DEB_W-1:0]  i_debounce_ms,
    output logic                             o_press
);
    import lpsc_pkg::*;

    localparam int CW = (TIME_BITS > DEB_W) ? TIME_BITS : DEB_W;

    logic                 r_raw, n_raw;
    logic                 r_stable, n_stable;
    logic [TIME_BITS-1:0] r_changed_at, n_changed_at;
    logic [TIME_BITS-1:0] elapsed;

    always_comb begin
        n_raw        = r_raw;
        n_changed_at = r_changed_at;
        if (i_level != r_raw) begin
            n_raw        = i_level;
            n_changed_at = i_now;
        end
        elapsed  = i_now - n_changed_at;
        n_stable = r_stable;
        o_press  = 1'b0;
        if ((CW'(elapsed) >= CW'(i_debounce_ms)) && (r_stable != n_raw)) begin
            n_stable = n_raw;
            o_press  = n_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw        <= 1'b0;
            r_stable     <= 1'b0;
            r_changed_at <= '0;
        end else if (i_step) begin
            r_raw        <= n_raw;
            r_stable     <= n_stable;
            r_changed_at <= n_changed_at;
        end
    end

endmodule

`default_nettype wire

### design/lpsc_select.sv
// ----------------------------------------------------------------------------
// lpsc_select
// Quadrature quarter-step decoder and five-way selection stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_select (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_en,
    input  wire logic                        i_quad_a,
    input  wire logic                        i_quad_b,
    output logic [lpsc_pkg::SEL_W-1:0]       o_sel
);
    import lpsc_pkg::*;

    logic [1:0]        r_prev, n_prev;
    logic signed [3:0] r_accum, n_accum;
    logic [SEL_W-1:0]  r_sel;
    logic [1:0]        cur;
    logic signed [1:0] qstep;
    logic signed [3:0] acc;
    t_detent           det;

    always_comb begin
        cur     = {i_quad_a, i_quad_b};
        qstep   = QUAD_STEP[{r_prev, cur}];
        acc     = r_accum + {{2{qstep[1]}}, qstep};
        n_prev  = r_prev;
        n_accum = r_accum;
        det     = '0;
        if (i_en) begin
            n_prev = cur;
            if (acc == DETENT_POS) begin
                n_accum = '0;
                det.up  = 1'b1;
            end else if (acc == DETENT_NEG) begin
                n_accum = '0;
                det.dn  = 1'b1;
            end else begin
                n_accum = acc;
            end
        end
        o_sel = r_sel;
        if (det.up) begin
            o_sel = (r_sel >= SEL_NONE) ? SEL_RED : r_sel + 3'd1;
        end else if (det.dn) begin
            o_sel = (r_sel == SEL_RED || r_sel > SEL_NONE) ? SEL_NONE : r_sel - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_accum <= '0;
            r_sel   <= SEL_NONE;
        end else if (i_step) begin
            r_prev  <= n_prev;
            r_accum <= n_accum;
            r_sel   <= o_sel;
        end
    end

endmodule

`default_nettype wire

### design/lpsc_timer.sv
// ----------------------------------------------------------------------------
// lpsc_timer
// Half-period phase timer on the wrapping millisecond count.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_timer #(
    parameter int TIME_BITS = 32,
    parameter int IW        = 17
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire lpsc_pkg::t_tmr_ctl    i_ctl,
    input  wire logic [TIME_BITS-1:0]  i_now,
    input  wire logic [IW-1:0]         i_interval,
    output logic                       o_phase
);
    import lpsc_pkg::*;

    localparam int CW = (TIME_BITS > IW) ? TIME_BITS : IW;

    logic [TIME_BITS-1:0] r_stamp, n_stamp;
    logic                 r_phase;
    logic                 phase_base;
    logic [TIME_BITS-1:0] elapsed;

    always_comb begin
        n_stamp    = i_ctl.restart ? i_now : r_stamp;
        phase_base = i_ctl.restart ? 1'b0 : r_phase;
        elapsed    = i_now - n_stamp;
        o_phase    = phase_base;
        if (i_ctl.en && (CW'(elapsed) >= CW'(i_interval))) begin
            n_stamp = i_now;
            o_phase = ~phase_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
            r_phase <= 1'b0;
        end else if (i_step) begin
            r_stamp <= n_stamp;
            r_phase <= o_phase;
        end
    end

endmodule

`default_nettype wire

### design/led_panel_selector_controller_core.sv
// A request accepted into the input stage moves to the result stage once the output
// can load (two registers: input stage, result stage). Throughput: one request per
// cycle unless the output stalls, set by the single combinational pass between them.
// Reset (synchronous, active low) clears all timers, debouncers and the decoder,
// selects none, leaves edit mode off and loads the default configuration.
// ----------------------------------------------------------------------------
// led_panel_selector_controller_core
// Button debounce, encoder selection and LED blink/hold control, one sample
// per request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_panel_selector_controller_core_defines.svh"

module led_panel_selector_controller_core #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire lpsc_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [lpsc_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_ms_tick,
    input  wire logic                          i_toggle_pressed,
    input  wire logic                          i_blink_pressed,
    input  wire logic                          i_knob_pressed,
    input  wire logic                          i_quad_a,
    input  wire logic                          i_quad_b,
    input  wire logic [lpsc_pkg::POT_W-1:0]    i_pot_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [lpsc_pkg::NUM_LEDS-1:0]      o_led_bits,
    output logic [2:0]                         o_rgb_bits,
    output logic [lpsc_pkg::SEL_W-1:0]         o_selection,
    output logic                               o_active
);
    import lpsc_pkg::*;

    logic [DEB_W-1:0]    r_debounce_ms;
    logic [BASE_W-1:0]   r_base_ms;
    logic [SCALE_W-1:0]  r_pot_scale;
    logic [FLASH_IW-1:0] r_rgb_ms;

    logic                r_in_valid;
    logic                r_tick, r_toggle, r_blink, r_knob, r_qa, r_qb;
    logic [BLINK_IW-1:0] r_interval;
    logic [PROD_W-1:0]   pot_prod;
    logic                accept, out_load, step;

    logic [TIME_BITS-1:0] r_ms, now;
    logic                 r_edit, n_edit;
    logic [NUM_LEDS-1:0]  r_hold_mode, n_hold_mode;
    logic [NUM_LEDS-1:0]  r_hold_level, n_hold_level;
    logic                 p_toggle, p_blink, p_knob;
    logic [SEL_W-1:0]     sel;
    logic                 sel_valid;
    logic                 blink_phase, flash_phase;
    t_tmr_ctl             blink_ctl, flash_ctl;
    logic [NUM_LEDS-1:0]  n_leds;
    logic [2:0]           n_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_base_ms     <= BASE_RST;
            r_pot_scale   <= SCALE_RST;
            r_rgb_ms      <= RGB_BLINK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:  r_debounce_ms <= i_cfg_data[DEB_W-1:0];
                CFG_BASE:      r_base_ms     <= i_cfg_data[BASE_W-1:0];
                CFG_POT_SCALE: r_pot_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_RGB_BLINK: r_rgb_ms      <= i_cfg_data[FLASH_IW-1:0];
                default:       r_debounce_ms <= r_debounce_ms;
            endcase
        end
    end

    assign out_load   = !o_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign accept     = i_in_valid && !o_in_stall;
    assign pot_prod   = i_pot_value[POT_W-1:2] * r_pot_scale;

    // input stage: register the sample and the blink half period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tick     <= i_ms_tick;
            r_toggle   <= i_toggle_pressed;
            r_blink    <= i_blink_pressed;
            r_knob     <= i_knob_pressed;
            r_qa       <= i_quad_a;
            r_qb       <= i_quad_b;
            r_interval <= BLINK_IW'(r_base_ms) + BLINK_IW'(pot_prod);
        end
    end

    assign now = r_ms + TIME_BITS'(r_tick);

    lpsc_debounce #(.TIME_BITS(TIME_BITS)) u_deb_toggle (
        .i_clk, .i_rst_n, .i_step(step), .i_level(r_toggle), .i_now(now),
        .i_debounce_ms(r_debounce_ms), .o_press(p_toggle)
    );

    lpsc_debounce #(.TIME_BITS(TIME_BITS)) u_deb_blink (
        .i_clk, .i_rst_n, .i_step(step), .i_level(r_blink), .i_now(now),
        .i_debounce_ms(r_debounce_ms), .o_press(p_blink)
    );

    lpsc_debounce #(.TIME_BITS(TIME_BITS)) u_deb_knob (
        .i_clk, .i_rst_n, .i_step(step), .i_level(r_knob), .i_now(now),
        .i_debounce_ms(r_debounce_ms), .o_press(p_knob)
    );

    lpsc_select u_select (
        .i_clk, .i_rst_n, .i_step(step), .i_en(!r_edit),
        .i_quad_a(r_qa), .i_quad_b(r_qb), .o_sel(sel)
    );

    assign sel_valid = sel < SEL_NONE;

    always_comb begin
        n_edit       = r_edit ^ p_knob;
        n_hold_mode  = r_hold_mode;
        n_hold_level = r_hold_level;
        if (p_toggle && n_edit && sel_valid) begin
            n_hold_mode[sel[1:0]]  = 1'b1;
            n_hold_level[sel[1:0]] = ~r_hold_level[sel[1:0]];
        end
        if (p_blink && n_edit && sel_valid) begin
            n_hold_mode[sel[1:0]] = 1'b0;
        end
    end

    assign blink_ctl = '{en: 1'b1, restart: 1'b0};
    assign flash_ctl = '{en: n_edit && sel_valid, restart: p_knob};

    lpsc_timer #(.TIME_BITS(TIME_BITS), .IW(BLINK_IW)) u_blink_tmr (
        .i_clk, .i_rst_n, .i_step(step), .i_ctl(blink_ctl), .i_now(now),
        .i_interval(r_interval), .o_phase(blink_phase)
    );

    lpsc_timer #(.TIME_BITS(TIME_BITS), .IW(FLASH_IW)) u_flash_tmr (
        .i_clk, .i_rst_n, .i_step(step), .i_ctl(flash_ctl), .i_now(now),
        .i_interval(r_rgb_ms), .o_phase(flash_phase)
    );

    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            n_leds[i] = n_hold_mode[i] ? n_hold_level[i] : blink_phase;
        end
        if (n_edit && sel_valid) begin
            n_rgb = flash_phase ? rgb_of_sel(sel) : 3'b000;
        end else begin
            n_rgb = rgb_of_sel(sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms         <= '0;
            r_edit       <= 1'b0;
            r_hold_mode  <= '0;
            r_hold_level <= '0;
        end else if (step) begin
            r_ms         <= now;
            r_edit       <= n_edit;
            r_hold_mode  <= n_hold_mode;
            r_hold_level <= n_hold_level;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_led_bits  <= n_leds;
            o_rgb_bits  <= n_rgb;
            o_selection <= sel;
            o_active    <= n_edit;
        end
    end

    `LPSC_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `LPSC_ASSERT_IMP(a_sel_range, i_clk, i_rst_n, o_out_valid, o_selection <= SEL_NONE)
    `LPSC_ASSERT_IMP(a_rgb_dark_on_none, i_clk, i_rst_n, o_out_valid && o_selection == SEL_NONE, o_rgb_bits == 3'b000)
    `LPSC_ASSERT_NXT(a_step_fills_output, i_clk, i_rst_n, step, o_out_valid)

endmodule

`default_nettype wire
